// ===== hdl/bpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the button press classifier: per-button
// state word, phase and kind codes, register indexes.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int NUM_BUTTONS = 2;
    localparam int BTN_W       = 1;
    localparam int COUNT_WIDTH = 20;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef logic [COUNT_WIDTH-1:0] t_count;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_FELL     = 3'd1,
        PH_HELD     = 3'd2,
        PH_ROSE     = 3'd3,
        PH_RELEASED = 3'd4,
        PH_DONE     = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_SHORT = 2'd1,
        KIND_LONG  = 2'd2,
        KIND_STUCK = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_THRESHOLD = 2'd0,
        CFG_LONG_THRESHOLD  = 2'd1,
        CFG_STUCK_THRESHOLD = 2'd2,
        CFG_POWER_INDEX     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic   last_level;
        t_phase phase;
        t_count held_ticks;
        t_count released_ticks;
        logic   pending_flag;
        t_kind  press_type;
    } t_btn_state;

    localparam t_btn_state STATE_RESET = '{
        last_level:     1'b0,
        phase:          PH_IDLE,
        held_ticks:     '0,
        released_ticks: '0,
        pending_flag:   1'b0,
        press_type:     KIND_NONE
    };

    function automatic t_count sat_inc(input t_count v);
        return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

endpackage

// ===== hdl/bpc_state_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_state_mem
// Per-button state memory: one write port, one registered read port.
// Entries not yet written read as the reset state.
// ----------------------------------------------------------------------------
module bpc_state_mem (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [bpc_pkg::BTN_W-1:0]    i_wr_addr,
    input  bpc_pkg::t_btn_state          i_wr_data,
    input  logic                         i_rd_en,
    input  logic [bpc_pkg::BTN_W-1:0]    i_rd_addr,
    output bpc_pkg::t_btn_state          o_rd_data
);
    import bpc_pkg::*;

    t_btn_state                mem [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0]    r_valid;
    t_btn_state                r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read returns the old word on a same-address write; the caller forwards
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_valid[i_rd_addr] ? mem[i_rd_addr] : STATE_RESET;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/button_press_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_classifier
// Classifies active-low button samples into short, long and stuck presses,
// with level-triggered behavior for the power button.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | to block  | i_in_valid / o_in_ready | i_button_id, i_pin_level
//  out     | from block| o_out_valid/ i_out_ready| o_report_button, o_press_flag,
//          |           |                         | o_press_kind, o_updated
//  cfg     | to block  | i_cfg_valid/ o_cfg_ready| i_cfg_index, i_cfg_data
//
//  One request per cycle sustained while the output is not stalled. The
//  accept edge reads the button's state word from the state memory; when the
//  update stage advances, it updates the word, writes it back and loads the
//  output register. A same-button request right behind is served by
//  forwarding the written word. Synchronous active-low reset; no clearing pass.
//  A stalled output holds the update stage, which then stops accepting requests.
// ----------------------------------------------------------------------------
module button_press_classifier (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [bpc_pkg::BTN_W-1:0]         i_button_id,
    input  logic                              i_pin_level,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [bpc_pkg::BTN_W-1:0]         o_report_button,
    output logic                              o_press_flag,
    output logic [1:0]                        o_press_kind,
    output logic                              o_updated,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bpc_pkg::*;

    t_count              r_short_thr;
    t_count              r_long_thr;
    t_count              r_stuck_thr;
    logic [BTN_W-1:0]    r_power_idx;

    logic                r_s1_valid;
    logic [BTN_W-1:0]    r_s1_button;
    logic                r_s1_pin;
    logic                r_fwd_hit;
    t_btn_state          r_fwd_state;

    logic                r_out_valid;
    logic [BTN_W-1:0]    r_out_button;
    logic                r_out_flag;
    t_kind               r_out_kind;
    logic                r_out_updated;

    logic                in_accept;
    logic                s1_advance;
    t_btn_state          rd_state;
    t_btn_state          cur_state;
    t_btn_state          n_state;
    logic                pwr;
    logic                n_updated;

    // ------------------------------------------------------------------ config
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_thr <= t_count'(5);
            r_long_thr  <= t_count'(100);
            r_stuck_thr <= t_count'(1000);
            r_power_idx <= BTN_W'(1);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SHORT_THRESHOLD: r_short_thr <= i_cfg_data;
                CFG_LONG_THRESHOLD:  r_long_thr  <= i_cfg_data;
                CFG_STUCK_THRESHOLD: r_stuck_thr <= i_cfg_data;
                CFG_POWER_INDEX:     r_power_idx <= i_cfg_data[BTN_W-1:0];
                default: ;
            endcase
        end
    end

    // --------------------------------------------------------------- handshake
    assign s1_advance = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_advance;
    assign in_accept  = i_in_valid && o_in_ready;

    bpc_state_mem u_state_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (s1_advance),
        .i_wr_addr (r_s1_button),
        .i_wr_data (n_state),
        .i_rd_en   (in_accept),
        .i_rd_addr (i_button_id),
        .o_rd_data (rd_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
                r_fwd_hit  <= s1_advance && (r_s1_button == i_button_id);
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
                r_fwd_hit  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_button <= i_button_id;
            r_s1_pin    <= i_pin_level;
            r_fwd_state <= n_state;
        end
    end

    // ------------------------------------------------------------ state update
    assign cur_state = r_fwd_hit ? r_fwd_state : rd_state;
    assign pwr       = (r_s1_button == r_power_idx);

    always_comb begin
        n_state = cur_state;

        case ({r_s1_pin, cur_state.last_level})
            2'b00: begin
                n_state.phase          = PH_HELD;
                n_state.held_ticks     = sat_inc(n_state.held_ticks);
                n_state.released_ticks = '0;
            end
            2'b10: begin
                n_state.phase          = PH_ROSE;
                n_state.held_ticks     = sat_inc(n_state.held_ticks);
                n_state.released_ticks = '0;
            end
            2'b11: begin
                if (n_state.phase == PH_HELD || n_state.phase == PH_ROSE) begin
                    n_state.phase = PH_RELEASED;
                end else if (n_state.phase == PH_DONE) begin
                    n_state.held_ticks = '0;
                end
                if (n_state.released_ticks < r_long_thr) begin
                    n_state.released_ticks = sat_inc(n_state.released_ticks);
                end
            end
            default: begin
                n_state.released_ticks = '0;
                n_state.phase          = PH_FELL;
                n_state.held_ticks     = sat_inc(n_state.held_ticks);
            end
        endcase

        // power button: a short release clears a pending press
        if (n_state.released_ticks >= r_short_thr && n_state.released_ticks < r_long_thr &&
            pwr && n_state.phase == PH_RELEASED && n_state.pending_flag) begin
            n_state.pending_flag   = 1'b0;
            n_state.press_type     = KIND_LONG;
            n_state.released_ticks = r_long_thr;
            n_state.phase          = PH_IDLE;
        end

        if (n_state.held_ticks >= r_short_thr && n_state.held_ticks < r_long_thr) begin
            if (pwr) begin
                if (n_state.phase == PH_HELD) begin
                    n_state.pending_flag   = 1'b1;
                    n_state.press_type     = KIND_LONG;
                    n_state.held_ticks     = '0;
                    n_state.released_ticks = '0;
                    n_state.phase          = PH_DONE;
                end
            end else if (n_state.phase == PH_RELEASED) begin
                n_state.pending_flag   = 1'b1;
                n_state.press_type     = KIND_SHORT;
                n_state.held_ticks     = '0;
                n_state.released_ticks = '0;
                n_state.phase          = PH_DONE;
            end
        end else if (n_state.held_ticks >= r_long_thr &&
                     n_state.held_ticks < r_stuck_thr) begin
            if (n_state.phase == PH_RELEASED) begin
                n_state.pending_flag = 1'b1;
                n_state.press_type   = KIND_LONG;
                n_state.held_ticks   = '0;
                n_state.phase        = PH_DONE;
            end
        end else if (n_state.held_ticks >= r_stuck_thr) begin
            if (n_state.phase == PH_RELEASED) begin
                n_state.pending_flag = 1'b0;
                n_state.press_type   = KIND_STUCK;
                n_state.held_ticks   = '0;
                n_state.phase        = PH_DONE;
            end
        end

        n_state.last_level = r_s1_pin;
    end

    assign n_updated = (n_state.pending_flag != cur_state.pending_flag) ||
                       (n_state.press_type != cur_state.press_type);

    // ----------------------------------------------------------- output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out_button  <= r_s1_button;
            r_out_flag    <= n_state.pending_flag;
            r_out_kind    <= n_state.press_type;
            r_out_updated <= n_updated;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_report_button = r_out_button;
    assign o_press_flag    = r_out_flag;
    assign o_press_kind    = r_out_kind;
    assign o_updated       = r_out_updated;

endmodule

// ===== dv/tb_button_press_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_press_classifier
// Self-checking bench for the button press classifier. Streams button samples
// through the request channel in random bursts, predicts every press report
// with an internal model of the per-button press tracking, and checks each
// report against it in order. Thresholds and the power button change between
// phases while the block is drained.
// ----------------------------------------------------------------------------
module tb_button_press_classifier;

    import bpc_pkg::*;

    localparam int RESET_CYCLES  = 11;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_SAMPLES = 140;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 10;
    localparam int MAX_RUN       = 110;
    localparam logic [CFG_DATA_W-1:0] THR_MAX = {CFG_DATA_W{1'b1}};

    typedef struct packed {
        logic btn;
        logic lvl;
    } t_button_sample;

    typedef struct packed {
        logic  btn;
        logic  flag;
        t_kind kind;
        logic  upd;
    } t_press_report;

    typedef struct packed {
        t_cfg_idx                idx;
        logic [CFG_DATA_W-1:0]   data;
    } t_reg_write;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [BTN_W-1:0]        i_button_id = '0;
    logic                    i_pin_level = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [BTN_W-1:0]        o_report_button;
    logic                    o_press_flag;
    logic [1:0]              o_press_kind;
    logic                    o_updated;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = CFG_SHORT_THRESHOLD;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    button_press_classifier DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_button_id     (i_button_id),
        .i_pin_level     (i_pin_level),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_report_button (o_report_button),
        .o_press_flag    (o_press_flag),
        .o_press_kind    (o_press_kind),
        .o_updated       (o_updated),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Press tracking model: thresholds and per-button state
    t_count thr_short = 20'd5;
    t_count thr_long  = 20'd100;
    t_count thr_stuck = 20'd1000;
    logic   power_btn = 1'b1;

    logic   last_lvl  [NUM_BUTTONS];
    t_phase btn_phase [NUM_BUTTONS];
    t_count held_cnt  [NUM_BUTTONS];
    t_count rel_cnt   [NUM_BUTTONS];
    logic   flag_q    [NUM_BUTTONS];
    t_kind  kind_q    [NUM_BUTTONS];

    t_button_sample pending_samples[$];
    t_reg_write     pending_writes[$];
    t_press_report  expected_reports[$];

    int samples_queued = 0;
    int results_seen   = 0;
    int regs_queued    = 0;
    int regs_written   = 0;
    int mismatches     = 0;
    int cycle_count    = 0;

    // Sample generator state per button
    int   gen_left    [NUM_BUTTONS];
    logic gen_level   [NUM_BUTTONS];
    bit   gen_release [NUM_BUTTONS];

    int burst_left = 0;
    int gap_left   = 0;
    t_button_sample next_sample;

    int  stall_mode  = 0;
    int  mode_age    = 0;
    int  hold_left   = 0;
    bit  long_hold_done = 1'b0;

    function automatic t_count bump(input t_count v);
        return (v == THR_MAX) ? v : v + 1'b1;
    endfunction

    function automatic t_press_report classify_sample(input logic btn, input logic lvl);
        t_press_report rep;
        logic          old_flag;
        t_kind         old_kind;
        logic          pwr;
        t_count        h;
        t_count        r;
        old_flag = flag_q[btn];
        old_kind = kind_q[btn];
        pwr = (btn == power_btn);

        if (!lvl && !last_lvl[btn]) begin
            btn_phase[btn] = PH_HELD;
            held_cnt[btn] = bump(held_cnt[btn]);
            rel_cnt[btn] = '0;
        end else if (lvl && !last_lvl[btn]) begin
            btn_phase[btn] = PH_ROSE;
            held_cnt[btn] = bump(held_cnt[btn]);
            rel_cnt[btn] = '0;
        end else if (lvl && last_lvl[btn]) begin
            if (btn_phase[btn] == PH_HELD || btn_phase[btn] == PH_ROSE)
                btn_phase[btn] = PH_RELEASED;
            else if (btn_phase[btn] == PH_DONE)
                held_cnt[btn] = '0;
            if (rel_cnt[btn] < thr_long)
                rel_cnt[btn] = bump(rel_cnt[btn]);
        end else begin
            rel_cnt[btn] = '0;
            btn_phase[btn] = PH_FELL;
            held_cnt[btn] = bump(held_cnt[btn]);
        end

        // a short-range release clears the power button's pending press
        r = rel_cnt[btn];
        if (r >= thr_short && r < thr_long && pwr &&
            btn_phase[btn] == PH_RELEASED && flag_q[btn]) begin
            flag_q[btn] = 1'b0;
            kind_q[btn] = KIND_LONG;
            rel_cnt[btn] = thr_long;
            btn_phase[btn] = PH_IDLE;
        end

        h = held_cnt[btn];
        if (h >= thr_short && h < thr_long) begin
            if (pwr) begin
                if (btn_phase[btn] == PH_HELD) begin
                    flag_q[btn] = 1'b1;
                    kind_q[btn] = KIND_LONG;
                    held_cnt[btn] = '0;
                    rel_cnt[btn] = '0;
                    btn_phase[btn] = PH_DONE;
                end
            end else if (btn_phase[btn] == PH_RELEASED) begin
                flag_q[btn] = 1'b1;
                kind_q[btn] = KIND_SHORT;
                held_cnt[btn] = '0;
                rel_cnt[btn] = '0;
                btn_phase[btn] = PH_DONE;
            end
        end else if (h >= thr_long && h < thr_stuck) begin
            if (btn_phase[btn] == PH_RELEASED) begin
                flag_q[btn] = 1'b1;
                kind_q[btn] = KIND_LONG;
                held_cnt[btn] = '0;
                btn_phase[btn] = PH_DONE;
            end
        end else if (h >= thr_stuck) begin
            if (btn_phase[btn] == PH_RELEASED) begin
                flag_q[btn] = 1'b0;
                kind_q[btn] = KIND_STUCK;
                held_cnt[btn] = '0;
                btn_phase[btn] = PH_DONE;
            end
        end

        last_lvl[btn] = lvl;
        rep.btn  = btn;
        rep.flag = flag_q[btn];
        rep.kind = kind_q[btn];
        rep.upd  = (flag_q[btn] != old_flag || kind_q[btn] != old_kind);
        return rep;
    endfunction

    // Run lengths cluster around the threshold edges; long ones fall back to short
    function automatic int run_len();
        int cand;
        case ($urandom_range(0, 9))
            0: cand = int'(thr_short) - 1;
            1: cand = int'(thr_short);
            2: cand = int'(thr_short) + 1;
            3: cand = int'(thr_long) - 1;
            4: cand = int'(thr_long);
            5: cand = int'(thr_long) + 1;
            6: cand = int'(thr_stuck) - 1;
            7: cand = int'(thr_stuck);
            8: cand = int'(thr_stuck) + 1;
            default: cand = $urandom_range(1, 8);
        endcase
        if (cand < 1 || cand > MAX_RUN)
            cand = $urandom_range(1, 12);
        return cand;
    endfunction

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return 0;
        else if (pick < 9)
            return $urandom_range(1, 4);
        return $urandom_range(5, 20);
    endfunction

    task automatic draw_level(input int b, output logic lvl);
        if (gen_left[b] == 0) begin
            if (gen_release[b]) begin
                gen_level[b] = 1'b1;
                gen_left[b] = run_len();
                gen_release[b] = 1'b0;
            end else if ($urandom_range(0, 6) == 0) begin
                // noise: short glitch of either level
                gen_level[b] = 1'($urandom_range(0, 1));
                gen_left[b] = $urandom_range(1, 3);
            end else begin
                gen_level[b] = 1'b0;
                gen_left[b] = run_len();
                gen_release[b] = 1'b1;
            end
        end
        gen_left[b]--;
        lvl = gen_level[b];
    endtask

    task automatic queue_sample(input logic btn, input logic lvl);
        t_button_sample s;
        s.btn = btn;
        s.lvl = lvl;
        pending_samples.push_back(s);
        samples_queued++;
    endtask

    task automatic wait_reports();
        while (results_seen != samples_queued)
            @(posedge i_clk);
    endtask

    task automatic load_thresholds(input logic [CFG_DATA_W-1:0] s_thr,
                                   input logic [CFG_DATA_W-1:0] l_thr,
                                   input logic [CFG_DATA_W-1:0] k_thr,
                                   input logic pwr);
        t_reg_write w;
        w.idx = CFG_SHORT_THRESHOLD; w.data = s_thr; pending_writes.push_back(w);
        w.idx = CFG_LONG_THRESHOLD;  w.data = l_thr; pending_writes.push_back(w);
        w.idx = CFG_STUCK_THRESHOLD; w.data = k_thr; pending_writes.push_back(w);
        w.idx = CFG_POWER_INDEX;     w.data = {{(CFG_DATA_W-1){1'b0}}, pwr};
        pending_writes.push_back(w);
        regs_queued += 4;
        while (regs_written != regs_queued)
            @(posedge i_clk);
    endtask

    // Register writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else if (!i_cfg_valid || o_cfg_ready) begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SHORT_THRESHOLD: thr_short = i_cfg_data;
                    CFG_LONG_THRESHOLD:  thr_long  = i_cfg_data;
                    CFG_STUCK_THRESHOLD: thr_stuck = i_cfg_data;
                    CFG_POWER_INDEX:     power_btn = i_cfg_data[0];
                    default: ;
                endcase
                regs_written++;
            end
            if (pending_writes.size() != 0) begin
                i_cfg_valid <= 1'b1;
                i_cfg_index <= pending_writes[0].idx;
                i_cfg_data  <= pending_writes[0].data;
                void'(pending_writes.pop_front());
            end else begin
                i_cfg_valid <= 1'b0;
            end
        end
    end

    // Sample requests in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                expected_reports.push_back(classify_sample(i_button_id, i_pin_level));
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    next_sample = pending_samples.pop_front();
                    i_in_valid  <= 1'b1;
                    i_button_id <= next_sample.btn;
                    i_pin_level <= next_sample.lvl;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left = gap_len();
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Report stalls, with one long hold-off to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            mode_age++;
            if (mode_age == 64) begin
                mode_age = 0;
                stall_mode = $urandom_range(0, 3);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!long_hold_done && results_seen >= 600) begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD;
                i_out_ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 9) < 7);
                    2: i_out_ready <= ($urandom_range(0, 9) < 3);
                    default: i_out_ready <= ~i_out_ready;
                endcase
            end
        end
    end

    // Report checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_reports.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected report: button %0d flag %0d kind %0d updated %0d",
                         $time, o_report_button, o_press_flag, o_press_kind, o_updated);
            end else if (o_report_button !== expected_reports[0].btn ||
                         o_press_flag !== expected_reports[0].flag ||
                         o_press_kind !== expected_reports[0].kind ||
                         o_updated !== expected_reports[0].upd) begin
                mismatches++;
                $display("%0t ns: report mismatch: expected button %0d flag %0d kind %0d upd %0d",
                         $time, expected_reports[0].btn, expected_reports[0].flag,
                         expected_reports[0].kind, expected_reports[0].upd);
                $display("%0t ns:                  actual button %0d flag %0d kind %0d upd %0d",
                         $time, o_report_button, o_press_flag, o_press_kind, o_updated);
            end
            if (expected_reports.size() != 0)
                void'(expected_reports.pop_front());
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_button_press_classifier NOT OK");
            $finish;
        end
    end

    initial begin
        int   ph;
        int   k;
        int   b;
        logic lv;
        logic [CFG_DATA_W-1:0] s_thr;
        logic [CFG_DATA_W-1:0] l_thr;
        logic [CFG_DATA_W-1:0] k_thr;
        logic pwr;
        for (k = 0; k < NUM_BUTTONS; k++) begin
            last_lvl[k]    = 1'b0;
            btn_phase[k]   = PH_IDLE;
            held_cnt[k]    = '0;
            rel_cnt[k]     = '0;
            flag_q[k]      = 1'b0;
            kind_q[k]      = KIND_NONE;
            gen_left[k]    = 0;
            gen_level[k]   = 1'b1;
            gen_release[k] = 1'b0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: long and stuck presses on the plain button; a stuck press
        // and a power press on the power button
        load_thresholds(20'd2, 20'd3, 20'd4, 1'b1);
        queue_sample(1'b0, 1'b1); queue_sample(1'b0, 1'b0);
        queue_sample(1'b0, 1'b1); queue_sample(1'b0, 1'b1);
        queue_sample(1'b0, 1'b0); queue_sample(1'b0, 1'b0);
        queue_sample(1'b0, 1'b1); queue_sample(1'b0, 1'b1);
        queue_sample(1'b1, 1'b1); queue_sample(1'b1, 1'b0);
        queue_sample(1'b1, 1'b0); queue_sample(1'b1, 1'b1);
        queue_sample(1'b1, 1'b1); queue_sample(1'b1, 1'b1);
        queue_sample(1'b0, 1'b0); queue_sample(1'b0, 1'b0);
        queue_sample(1'b0, 1'b0); queue_sample(1'b0, 1'b1);
        queue_sample(1'b0, 1'b1); queue_sample(1'b1, 1'b0);
        queue_sample(1'b1, 1'b0); queue_sample(1'b1, 1'b0);
        queue_sample(1'b1, 1'b1);
        wait_reports();

        b = 0;
        for (ph = 0; ph < 10; ph++) begin
            pwr = 1'($urandom_range(0, 1));
            case (ph)
                0: begin s_thr = 20'd3;  l_thr = 20'd10;  k_thr = 20'd20;   pwr = 1'b1; end
                1: begin s_thr = 20'd1;  l_thr = 20'd6;   k_thr = 20'd12;   pwr = 1'b0; end
                2: begin s_thr = 20'd0;  l_thr = 20'd0;   k_thr = 20'd0;   end
                3: begin s_thr = THR_MAX; l_thr = THR_MAX; k_thr = THR_MAX; end
                4: begin s_thr = 20'd8;  l_thr = 20'd3;   k_thr = 20'd15;  end
                5: begin s_thr = 20'd4;  l_thr = 20'd12;  k_thr = 20'd7;   end
                6: begin s_thr = 20'd0;  l_thr = THR_MAX; k_thr = THR_MAX; end
                7: begin s_thr = 20'd5;  l_thr = 20'd100; k_thr = 20'd1000; pwr = 1'b1; end
                default: begin
                    s_thr = CFG_DATA_W'($urandom_range(0, 12));
                    l_thr = CFG_DATA_W'($urandom_range(0, 30));
                    k_thr = CFG_DATA_W'($urandom_range(0, 40));
                end
            endcase
            load_thresholds(s_thr, l_thr, k_thr, pwr);
            for (k = 0; k < PHASE_SAMPLES; k++) begin
                // mostly stay on one button, switch now and then
                if ($urandom_range(0, 3) == 0)
                    b = 1 - b;
                draw_level(b, lv);
                queue_sample(b[0], lv);
            end
            wait_reports();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("tb_button_press_classifier OK");
        else
            $display("tb_button_press_classifier NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/bpc_pkg.sv
hdl/bpc_state_mem.sv
hdl/button_press_classifier.sv
dv/tb_button_press_classifier.sv
